// ===== hdl/ats_pkg.sv =====
// Shared types, constants and saturation helpers for the affine transform stack.
package ats_pkg;

    localparam int DATA_W          = 32;
    localparam int COEF_N          = 6;
    localparam int VH_W            = 31;
    localparam int STAT_W          = 3;
    localparam int IDX_W           = 3;
    localparam int QUEUE_DEPTH     = 2;
    localparam int STACK_DEPTH_DEF = 16;
    localparam int MAX_NESTING_DEF = 255;
    localparam int FRAC_BITS_DEF   = 16;

    typedef logic signed [DATA_W-1:0] word_t;

    typedef enum logic [1:0] {
        OP_ENTER = 2'd0,
        OP_EXIT  = 2'd1,
        OP_PUSH  = 2'd2,
        OP_MAP   = 2'd3
    } op_t;

    typedef enum logic [STAT_W-1:0] {
        STAT_DONE      = 3'd0,
        STAT_POINT     = 3'd1,
        STAT_FULL      = 3'd2,
        STAT_EXIT_ZERO = 3'd3,
        STAT_NEST_SAT  = 3'd4
    } status_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_CALC,
        ST_DRAIN,
        ST_FINISH
    } state_t;

    // last combine index issued per op
    localparam logic [IDX_W-1:0] PUSH_LAST = 3'd5;
    localparam logic [IDX_W-1:0] MAP_LAST  = 3'd1;

    typedef struct packed {
        op_t                           op;
        logic [COEF_N-1:0][DATA_W-1:0] opnd;
    } q_item_t;

    typedef struct packed {
        logic             vld;
        logic [IDX_W-1:0] idx;
        word_t            m1;
        word_t            n1;
        word_t            m2;
        word_t            n2;
        word_t            t;
    } comb_req_t;

    typedef struct packed {
        logic             vld;
        logic [IDX_W-1:0] idx;
        word_t            value;
    } comb_rsp_t;

    // clamp a 65-bit sum to 64-bit signed
    function automatic logic signed [63:0] sat64(input logic signed [64:0] v);
        logic signed [63:0] r;
        if (v[64] != v[63])
        begin
            r = v[64] ? {1'b1, {63{1'b0}}} : {1'b0, {63{1'b1}}};
        end
        else
        begin
            r = v[63:0];
        end
        return r;
    endfunction

    // clamp a 64-bit value to a 32-bit signed word
    function automatic word_t sat_word(input logic signed [63:0] v);
        word_t r;
        if ((&v[63:DATA_W-1]) || !(|v[63:DATA_W-1]))
        begin
            r = v[DATA_W-1:0];
        end
        else
        begin
            r = v[63] ? {1'b1, {(DATA_W-1){1'b0}}} : {1'b0, {(DATA_W-1){1'b1}}};
        end
        return r;
    endfunction

endpackage

// ===== hdl/ats_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module ats_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== hdl/ats_fifo.sv =====
// Short request queue between the front end and the execution back end.
module ats_fifo (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  ats_pkg::q_item_t push_item,
    output logic             full,
    input  logic             pop,
    output ats_pkg::q_item_t pop_item,
    output logic             empty
);
    import ats_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

    q_item_t          entries_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entries_reg[wr_ptr_reg] <= push_item;
        end
    end

    assign pop_item = entries_reg[rd_ptr_reg];
    assign empty    = (cnt_reg == '0);
    assign full     = (cnt_reg == CNT_FULL);

endmodule

// ===== hdl/ats_front.sv =====
// Front end: accepts requests, decodes the command and packs operands for the queue.
module ats_front (
    input  logic                             in_valid,
    output logic                             in_stall,
    input  logic [1:0]                       cmd,
    input  logic signed [ats_pkg::DATA_W-1:0] coef_a,
    input  logic signed [ats_pkg::DATA_W-1:0] coef_b,
    input  logic signed [ats_pkg::DATA_W-1:0] coef_c,
    input  logic signed [ats_pkg::DATA_W-1:0] coef_d,
    input  logic signed [ats_pkg::DATA_W-1:0] shift_x,
    input  logic signed [ats_pkg::DATA_W-1:0] shift_y,
    input  logic signed [ats_pkg::DATA_W-1:0] point_x,
    input  logic signed [ats_pkg::DATA_W-1:0] point_y,
    input  logic                             q_full,
    output logic                             q_push,
    output ats_pkg::q_item_t                 q_item
);
    import ats_pkg::*;

    op_t op;

    assign op       = op_t'(cmd);
    assign in_stall = q_full;
    assign q_push   = in_valid && !q_full;

    // push carries a..f in slots 0..5, map carries x, y in slots 0, 1
    always_comb
    begin
        q_item.op = op;
        case (op)
            OP_PUSH:
            begin
                q_item.opnd = {shift_y, shift_x, coef_d, coef_c, coef_b, coef_a};
            end
            OP_MAP:
            begin
                q_item.opnd = {{(4*DATA_W){1'b0}}, point_y, point_x};
            end
            default:
            begin
                q_item.opnd = '0;
            end
        endcase
    end

endmodule

// ===== hdl/ats_comb.sv =====
// Four-stage product-sum unit: two products, saturating adds, rounding, 32-bit clamp.
module ats_comb #(
    parameter int FRAC_BITS = ats_pkg::FRAC_BITS_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  ats_pkg::comb_req_t req,
    output ats_pkg::comb_rsp_t rsp,
    output logic               busy
);
    import ats_pkg::*;

    localparam logic signed [63:0] HALF = 64'sd1 <<< (FRAC_BITS - 1);

    logic               v1_reg, v2_reg, v3_reg, v4_reg;
    logic [IDX_W-1:0]   idx1_reg, idx2_reg, idx3_reg, idx4_reg;
    logic signed [63:0] p1_reg, p2_reg, p1_next, p2_next;
    word_t              t1_reg, t2_reg;
    logic signed [63:0] s1_reg, s1_next;
    logic signed [63:0] s2_reg, s2_next;
    logic signed [63:0] t_scaled, s3, q;
    word_t              res_reg, res_next;

    always_comb
    begin
        p1_next  = req.m1 * req.n1;
        p2_next  = req.m2 * req.n2;
        s1_next  = sat64(65'(p1_reg) + 65'(p2_reg));
        t_scaled = 64'(t2_reg) <<< FRAC_BITS;
        s2_next  = sat64(65'(s1_reg) + 65'(t_scaled));
        s3       = sat64(65'(s2_reg) + 65'(HALF));
        q        = s3 >>> FRAC_BITS;
        res_next = sat_word(q);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= req.vld;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        idx1_reg <= req.idx;
        p1_reg   <= p1_next;
        p2_reg   <= p2_next;
        t1_reg   <= req.t;
        idx2_reg <= idx1_reg;
        s1_reg   <= s1_next;
        t2_reg   <= t1_reg;
        idx3_reg <= idx2_reg;
        s2_reg   <= s2_next;
        idx4_reg <= idx3_reg;
        res_reg  <= res_next;
    end

    assign rsp.vld   = v4_reg;
    assign rsp.idx   = idx4_reg;
    assign rsp.value = res_reg;
    assign busy      = v1_reg || v2_reg || v3_reg || v4_reg;

endmodule

// ===== hdl/ats_back.sv =====
// Back end: sequencer, current transform, stack memory and result register.
module ats_back #(
    parameter int STACK_DEPTH = ats_pkg::STACK_DEPTH_DEF,
    parameter int MAX_NESTING = ats_pkg::MAX_NESTING_DEF,
    parameter int FRAC_BITS   = ats_pkg::FRAC_BITS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              q_empty,
    input  ats_pkg::q_item_t                  q_item,
    output logic                              q_pop,
    input  logic [ats_pkg::VH_W-1:0]          viewport_height,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic signed [ats_pkg::DATA_W-1:0] mapped_x,
    output logic signed [ats_pkg::DATA_W-1:0] mapped_y,
    output logic [ats_pkg::STAT_W-1:0]        status
);
    import ats_pkg::*;

    localparam int ADDR_W = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int CNT_W  = $clog2(STACK_DEPTH + 1);
    localparam int LVL_W  = $clog2(MAX_NESTING + 1);
    localparam int MAT_W  = COEF_N * DATA_W;
    localparam int ROW_W  = MAT_W + LVL_W;
    localparam logic [CNT_W-1:0]  CNT_FULL = CNT_W'(STACK_DEPTH);
    localparam logic [LVL_W-1:0]  LVL_MAX  = LVL_W'(MAX_NESTING);
    localparam logic [DATA_W-1:0] ONE      = DATA_W'(1) << FRAC_BITS;

    typedef logic [COEF_N-1:0][DATA_W-1:0] mat_t;

    state_t            state_reg, st_next;
    q_item_t           work_reg;
    mat_t              cur_reg, cur_next;
    mat_t              r_reg;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [LVL_W-1:0]  lvl_reg, lvl_next;
    logic [IDX_W-1:0]  iss_reg, iss_next;
    logic              out_valid_reg, out_valid_next;
    word_t             mx_reg, mx_next;
    word_t             my_reg, my_next;
    status_t           status_reg, status_next;

    logic              out_free, commit, ram_re, ram_we, issue, busy;
    logic [IDX_W-1:0]  last_idx;
    logic [ROW_W-1:0]  rd_row;
    logic [LVL_W-1:0]  rd_lvl;
    mat_t              rd_mat;
    logic              row_sel;
    logic [1:0]        pair_sel;
    word_t             ty;
    logic signed [33:0] dy;
    comb_req_t         req;
    comb_rsp_t         rsp;

    assign out_free = !out_valid_reg || !out_stall;
    assign last_idx = (work_reg.op == OP_PUSH) ? PUSH_LAST : MAP_LAST;

    // next state
    always_comb
    begin
        st_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (!q_empty)
                begin
                    case (q_item.op)
                        OP_EXIT:  st_next = (cnt_reg != '0) ? ST_READ : ST_FINISH;
                        OP_PUSH:  st_next = (cnt_reg == CNT_FULL) ? ST_FINISH : ST_CALC;
                        OP_MAP:   st_next = ST_CALC;
                        default:  st_next = ST_FINISH;
                    endcase
                end
            end
            ST_READ:
            begin
                st_next = ST_FINISH;
            end
            ST_CALC:
            begin
                if (iss_reg == last_idx)
                begin
                    st_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (!busy)
                begin
                    st_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (out_free)
                begin
                    st_next = ST_IDLE;
                end
            end
            default:
            begin
                st_next = ST_IDLE;
            end
        endcase
    end

    // control outputs
    always_comb
    begin
        q_pop  = 1'b0;
        ram_re = 1'b0;
        issue  = 1'b0;
        commit = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                q_pop  = !q_empty;
                ram_re = !q_empty && (q_item.op == OP_EXIT) && (cnt_reg != '0);
            end
            ST_CALC:
            begin
                issue = 1'b1;
            end
            ST_FINISH:
            begin
                commit = out_free;
            end
            default:
            begin
                q_pop = 1'b0;
            end
        endcase
    end

    // combine operands: bit 0 picks the output row, bits 2:1 the operand pair
    always_comb
    begin
        row_sel  = iss_reg[0];
        pair_sel = iss_reg[2:1];
        req.vld  = issue;
        req.idx  = iss_reg;
        req.m1   = word_t'(row_sel ? cur_reg[1] : cur_reg[0]);
        req.m2   = word_t'(row_sel ? cur_reg[3] : cur_reg[2]);
        if ((work_reg.op == OP_MAP) || (pair_sel == 2'd2))
        begin
            req.t = word_t'(row_sel ? cur_reg[5] : cur_reg[4]);
        end
        else
        begin
            req.t = '0;
        end
        case (pair_sel)
            2'd0:
            begin
                req.n1 = word_t'(work_reg.opnd[0]);
                req.n2 = word_t'(work_reg.opnd[1]);
            end
            2'd1:
            begin
                req.n1 = word_t'(work_reg.opnd[2]);
                req.n2 = word_t'(work_reg.opnd[3]);
            end
            default:
            begin
                req.n1 = word_t'(work_reg.opnd[4]);
                req.n2 = word_t'(work_reg.opnd[5]);
            end
        endcase
    end

    assign iss_next = (state_reg == ST_CALC) ? iss_reg + 1'b1 :
                      (state_reg == ST_IDLE) ? '0 : iss_reg;

    assign rd_lvl = rd_row[ROW_W-1 -: LVL_W];
    assign rd_mat = rd_row[MAT_W-1:0];
    assign ty     = word_t'(r_reg[1]);
    assign dy     = $signed({3'b000, viewport_height}) - {{2{ty[DATA_W-1]}}, ty};

    // state update and result at the end of an item
    always_comb
    begin
        cur_next       = cur_reg;
        cnt_next       = cnt_reg;
        lvl_next       = lvl_reg;
        ram_we         = 1'b0;
        mx_next        = mx_reg;
        my_next        = my_reg;
        status_next    = status_reg;
        out_valid_next = out_valid_reg && out_stall;
        if (commit)
        begin
            out_valid_next = 1'b1;
            mx_next        = '0;
            my_next        = '0;
            status_next    = STAT_DONE;
            case (work_reg.op)
                OP_ENTER:
                begin
                    if (lvl_reg == LVL_MAX)
                    begin
                        status_next = STAT_NEST_SAT;
                    end
                    else
                    begin
                        lvl_next = lvl_reg + 1'b1;
                    end
                end
                OP_EXIT:
                begin
                    if ((cnt_reg != '0) && (rd_lvl == lvl_reg))
                    begin
                        cnt_next = cnt_reg - 1'b1;
                        cur_next = rd_mat;
                    end
                    if (lvl_reg == '0)
                    begin
                        status_next = STAT_EXIT_ZERO;
                    end
                    else
                    begin
                        lvl_next = lvl_reg - 1'b1;
                    end
                end
                OP_PUSH:
                begin
                    if (cnt_reg == CNT_FULL)
                    begin
                        status_next = STAT_FULL;
                    end
                    else
                    begin
                        ram_we   = 1'b1;
                        cur_next = r_reg;
                        cnt_next = cnt_reg + 1'b1;
                    end
                end
                default:
                begin
                    mx_next     = word_t'(r_reg[0]);
                    my_next     = sat_word(64'(dy));
                    status_next = STAT_POINT;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cur_reg       <= {{(2*DATA_W){1'b0}}, ONE, {(2*DATA_W){1'b0}}, ONE};
            cnt_reg       <= '0;
            lvl_reg       <= '0;
            iss_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= st_next;
            cur_reg       <= cur_next;
            cnt_reg       <= cnt_next;
            lvl_reg       <= lvl_next;
            iss_reg       <= iss_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            work_reg <= q_item;
        end
        if (rsp.vld)
        begin
            r_reg[rsp.idx] <= rsp.value;
        end
        mx_reg     <= mx_next;
        my_reg     <= my_next;
        status_reg <= status_next;
    end

    ats_comb #(
        .FRAC_BITS(FRAC_BITS)
    ) u_comb (
        .clk  (clk),
        .rst_n(rst_n),
        .req  (req),
        .rsp  (rsp),
        .busy (busy)
    );

    ats_ram #(
        .WIDTH(ROW_W),
        .DEPTH(STACK_DEPTH)
    ) u_stack (
        .clk  (clk),
        .we   (ram_we),
        .waddr(cnt_reg[ADDR_W-1:0]),
        .wdata({lvl_reg, cur_reg}),
        .re   (ram_re),
        .raddr(ADDR_W'(cnt_reg - 1'b1)),
        .rdata(rd_row)
    );

    assign out_valid = out_valid_reg;
    assign mapped_x  = mx_reg;
    assign mapped_y  = my_reg;
    assign status    = status_reg;

endmodule

// ===== hdl/affine_transform_stack_unit.sv =====
// Top level of the nested 2D affine transform stack (Q16.16 by default).
// Path: a request is queued, popped by the idle back end, then steps through READ (exit on a
//   non-empty stack) or CALC and DRAIN (map, push with room) to FINISH, which loads the result.
// The back end takes one request at a time and holds in FINISH while the output stalls; the
//   sequencer issues one product pair per cycle into a four-stage combine pipeline.
// Reset: identity transform, empty stack, level and viewport height zero; stack RAM not cleared.
module affine_transform_stack_unit #(
    parameter int STACK_DEPTH = ats_pkg::STACK_DEPTH_DEF,
    parameter int MAX_NESTING = ats_pkg::MAX_NESTING_DEF,
    parameter int FRAC_BITS   = ats_pkg::FRAC_BITS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_write,
    input  logic [ats_pkg::VH_W-1:0]          cfg_data,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic [1:0]                        cmd,
    input  logic signed [ats_pkg::DATA_W-1:0] coef_a,
    input  logic signed [ats_pkg::DATA_W-1:0] coef_b,
    input  logic signed [ats_pkg::DATA_W-1:0] coef_c,
    input  logic signed [ats_pkg::DATA_W-1:0] coef_d,
    input  logic signed [ats_pkg::DATA_W-1:0] shift_x,
    input  logic signed [ats_pkg::DATA_W-1:0] shift_y,
    input  logic signed [ats_pkg::DATA_W-1:0] point_x,
    input  logic signed [ats_pkg::DATA_W-1:0] point_y,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic signed [ats_pkg::DATA_W-1:0] mapped_x,
    output logic signed [ats_pkg::DATA_W-1:0] mapped_y,
    output logic [ats_pkg::STAT_W-1:0]        status
);
    import ats_pkg::*;

    // viewport height, to be written only while the block is idle; the block does not enforce it
    logic [VH_W-1:0] vh_reg;

    // queue between front and back
    logic    q_push, q_full, q_pop, q_empty;
    q_item_t q_in_item, q_out_item;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vh_reg <= '0;
        end
        else if (cfg_write)
        begin
            vh_reg <= cfg_data;
        end
    end

    // front: takes a request whenever the queue has room
    ats_front u_front (
        .in_valid(in_valid),
        .in_stall(in_stall),
        .cmd     (cmd),
        .coef_a  (coef_a),
        .coef_b  (coef_b),
        .coef_c  (coef_c),
        .coef_d  (coef_d),
        .shift_x (shift_x),
        .shift_y (shift_y),
        .point_x (point_x),
        .point_y (point_y),
        .q_full  (q_full),
        .q_push  (q_push),
        .q_item  (q_in_item)
    );

    ats_fifo u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_item(q_in_item),
        .full     (q_full),
        .pop      (q_pop),
        .pop_item (q_out_item),
        .empty    (q_empty)
    );

    // back: one request at a time; the result register lets the queue keep filling
    ats_back #(
        .STACK_DEPTH(STACK_DEPTH),
        .MAX_NESTING(MAX_NESTING),
        .FRAC_BITS  (FRAC_BITS)
    ) u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .q_empty        (q_empty),
        .q_item         (q_out_item),
        .q_pop          (q_pop),
        .viewport_height(vh_reg),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .mapped_x       (mapped_x),
        .mapped_y       (mapped_y),
        .status         (status)
    );

    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> !q_empty)
        else $error("back end popped an empty queue");

    a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
        q_push |-> !q_full)
        else $error("front end pushed into a full queue");

    a_zero_coords: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (status != STAT_POINT)) |-> ((mapped_x == '0) && (mapped_y == '0)))
        else $error("non-map result carries coordinates");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (status == STAT_DONE || status == STAT_POINT || status == STAT_FULL
                       || status == STAT_EXIT_ZERO || status == STAT_NEST_SAT))
        else $error("result status out of range");

endmodule

// ===== verif/affine_transform_stack_unit_test.sv =====
// Self-checking testbench for the nested affine transform stack unit.
module affine_transform_stack_unit_test;
    import ats_pkg::*;

    localparam int STACK  = STACK_DEPTH_DEF;
    localparam int NEST   = MAX_NESTING_DEF;
    localparam int FRAC   = FRAC_BITS_DEF;

    localparam word_t W_MAX = 32'sh7FFF_FFFF;
    localparam word_t W_MIN = 32'sh8000_0000;
    localparam word_t W_ONE = 32'sh0001_0000;

    // one request as seen on the input channel
    typedef struct packed {
        op_t   op;
        word_t a, b, c, d, e, f;
        word_t px, py;
    } xf_request_t;

    // one result as seen on the output channel
    typedef struct packed {
        word_t   x;
        word_t   y;
        status_t st;
    } xf_result_t;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                cfg_write = 1'b0;
    logic [VH_W-1:0]     cfg_data = '0;
    logic                in_valid = 1'b0;
    logic                in_stall;
    logic [1:0]          cmd = '0;
    word_t               coef_a = '0;
    word_t               coef_b = '0;
    word_t               coef_c = '0;
    word_t               coef_d = '0;
    word_t               shift_x = '0;
    word_t               shift_y = '0;
    word_t               point_x = '0;
    word_t               point_y = '0;
    logic                out_valid;
    logic                out_stall = 1'b0;
    word_t               mapped_x;
    word_t               mapped_y;
    logic [STAT_W-1:0]   status;

    // predicted block state, advanced at each accepted request
    word_t               cur_xf [COEF_N];
    word_t               saved_xf [STACK*COEF_N];
    logic [7:0]          saved_level [STACK];
    int                  depth_used;
    int                  nest_level;
    logic [VH_W-1:0]     viewport_h;

    xf_result_t          pending_results [$];
    int                  mismatch_count = 0;
    int                  items_sent = 0;
    bit                  quiet = 1'b0;   // no idling on either side while set

    affine_transform_stack_unit i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .cmd       (cmd),
        .coef_a    (coef_a),
        .coef_b    (coef_b),
        .coef_c    (coef_c),
        .coef_d    (coef_d),
        .shift_x   (shift_x),
        .shift_y   (shift_y),
        .point_x   (point_x),
        .point_y   (point_y),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .mapped_x  (mapped_x),
        .mapped_y  (mapped_y),
        .status    (status)
    );

    always #10 clk = ~clk;

    // hard stop in case the block hangs
    initial
    begin
        #10_000_000;
        $display("end of test: mismatches");
        $finish;
    end

    // ------------------------------------------------------------------
    // Fixed-point arithmetic of the predictor
    // ------------------------------------------------------------------

    // 64-bit signed add that clamps instead of wrapping
    function automatic longint clamp_sum(input longint x, input longint y);
        logic [64:0] s;
        s = {x[63], x} + {y[63], y};
        if (s[64] != s[63])
            return s[64] ? {1'b1, {63{1'b0}}} : {1'b0, {63{1'b1}}};
        return s[63:0];
    endfunction

    function automatic word_t clamp_word(input longint v);
        if (v > 64'sd2147483647)
            return W_MAX;
        if (v < -64'sd2147483648)
            return W_MIN;
        return v[31:0];
    endfunction

    // m1*n1 + m2*n2 + t, rounded half up back to Q16.16 and clamped
    function automatic word_t mac_round(input word_t m1, input word_t n1,
                                        input word_t m2, input word_t n2,
                                        input word_t t);
        longint acc;
        acc = longint'(m1) * longint'(n1);
        acc = clamp_sum(acc, longint'(m2) * longint'(n2));
        acc = clamp_sum(acc, longint'(t) * (longint'(1) <<< FRAC));
        acc = clamp_sum(acc, longint'(1) <<< (FRAC - 1));
        return clamp_word(acc >>> FRAC);
    endfunction

    function automatic void reset_transform_state();
        cur_xf[0]  = W_ONE;
        cur_xf[1]  = '0;
        cur_xf[2]  = '0;
        cur_xf[3]  = W_ONE;
        cur_xf[4]  = '0;
        cur_xf[5]  = '0;
        depth_used = 0;
        nest_level = 0;
        viewport_h = '0;
    endfunction

    // Advances the predicted state by one request and returns its result.
    function automatic xf_result_t apply_transform_cmd(input xf_request_t rq);
        xf_result_t res;
        word_t      r [COEF_N];
        word_t      ty;
        res = '{x: '0, y: '0, st: STAT_DONE};
        case (rq.op)
            OP_ENTER:
            begin
                if (nest_level >= NEST)
                    res.st = STAT_NEST_SAT;
                else
                    nest_level++;
            end
            OP_EXIT:
            begin
                // restore only what was pushed at the level being left
                if (depth_used > 0 && saved_level[depth_used-1] == nest_level)
                begin
                    depth_used--;
                    for (int k = 0; k < COEF_N; k++)
                        cur_xf[k] = saved_xf[depth_used*COEF_N + k];
                end
                if (nest_level == 0)
                    res.st = STAT_EXIT_ZERO;
                else
                    nest_level--;
            end
            OP_PUSH:
            begin
                if (depth_used >= STACK)
                    res.st = STAT_FULL;
                else
                begin
                    r[0] = mac_round(cur_xf[0], rq.a, cur_xf[2], rq.b, '0);
                    r[1] = mac_round(cur_xf[1], rq.a, cur_xf[3], rq.b, '0);
                    r[2] = mac_round(cur_xf[0], rq.c, cur_xf[2], rq.d, '0);
                    r[3] = mac_round(cur_xf[1], rq.c, cur_xf[3], rq.d, '0);
                    r[4] = mac_round(cur_xf[0], rq.e, cur_xf[2], rq.f, cur_xf[4]);
                    r[5] = mac_round(cur_xf[1], rq.e, cur_xf[3], rq.f, cur_xf[5]);
                    for (int k = 0; k < COEF_N; k++)
                    begin
                        saved_xf[depth_used*COEF_N + k] = cur_xf[k];
                        cur_xf[k] = r[k];
                    end
                    saved_level[depth_used] = nest_level[7:0];
                    depth_used++;
                end
            end
            default:
            begin
                res.x  = mac_round(cur_xf[0], rq.px, cur_xf[2], rq.py, cur_xf[4]);
                ty     = mac_round(cur_xf[1], rq.px, cur_xf[3], rq.py, cur_xf[5]);
                res.y  = clamp_word(longint'(viewport_h) - longint'(ty));
                res.st = STAT_POINT;
            end
        endcase
        return res;
    endfunction

    // ------------------------------------------------------------------
    // Random values
    // ------------------------------------------------------------------

    // scale-like coefficient in [-1.5, 1.5]
    function automatic word_t rand_unit();
        return word_t'($urandom_range(0, 196608)) - 32'sd98304;
    endfunction

    // translation or coordinate in [-64, 64], now and then anything
    function automatic word_t rand_offset();
        if ($urandom_range(0, 9) < 2)
            return $urandom;
        return word_t'($urandom_range(0, 1 << 23)) - 32'sd4194304;
    endfunction

    function automatic word_t rand_coef();
        case ($urandom_range(0, 9))
            0:       return $urandom;
            1:       return word_t'($urandom_range(0, 8192)) - 32'sd4096;
            default: return rand_unit();
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Request driver: payload changes at the falling edge, acceptance is
    // seen at the rising edge. Valid is left high after acceptance; the
    // next call or idle_inputs() replaces or lowers it at the next fall.
    // ------------------------------------------------------------------
    task automatic send_request(input xf_request_t rq);
        @(negedge clk);
        while (!quiet && $urandom_range(0, 99) < 12)
        begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        cmd      = rq.op;
        coef_a   = rq.a;
        coef_b   = rq.b;
        coef_c   = rq.c;
        coef_d   = rq.d;
        shift_x  = rq.e;
        shift_y  = rq.f;
        point_x  = rq.px;
        point_y  = rq.py;
        in_valid = 1'b1;
        forever
        begin
            @(posedge clk);
            if (!in_stall)
                break;
        end
        pending_results.insert(pending_results.size(), apply_transform_cmd(rq));
        items_sent++;
    endtask

    // enter/exit: unused fields carry random bits
    task automatic send_cmd(input op_t op);
        send_request('{op: op, a: $urandom, b: $urandom, c: $urandom, d: $urandom,
                       e: $urandom, f: $urandom, px: $urandom, py: $urandom});
    endtask

    task automatic send_push(input word_t a, input word_t b, input word_t c,
                             input word_t d, input word_t e, input word_t f);
        send_request('{op: OP_PUSH, a: a, b: b, c: c, d: d, e: e, f: f,
                       px: $urandom, py: $urandom});
    endtask

    task automatic send_map(input word_t x, input word_t y);
        send_request('{op: OP_MAP, a: $urandom, b: $urandom, c: $urandom, d: $urandom,
                       e: $urandom, f: $urandom, px: x, py: y});
    endtask

    task automatic send_rand_push();
        send_push(rand_coef(), rand_coef(), rand_coef(), rand_coef(),
                  rand_offset(), rand_offset());
    endtask

    task automatic idle_inputs();
        @(negedge clk);
        in_valid = 1'b0;
    endtask

    // Viewport height is only written once every result is back, so the
    // block is idle when the write lands.
    task automatic set_viewport(input logic [VH_W-1:0] h);
        idle_inputs();
        while (pending_results.size() != 0)
            @(negedge clk);
        cfg_data  = h;
        cfg_write = 1'b1;
        @(negedge clk);
        cfg_write = 1'b0;
        viewport_h = h;
    endtask

    // Walks the level toward each stacked entry and exits there, until
    // the stack is empty and the level is back at zero.
    task automatic unwind_stack();
        while (depth_used != 0)
        begin
            if (saved_level[depth_used-1] > nest_level)
                send_cmd(OP_ENTER);
            else
                send_cmd(OP_EXIT);
        end
        while (nest_level != 0)
            send_cmd(OP_EXIT);
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // corner points through the current transform; y flip saturates
    task automatic test_map_extremes();
        send_map('0, '0);
        send_map(W_MAX, W_MAX);
        send_map(W_MIN, W_MIN);
        send_map(W_MAX, W_MIN);
        send_map(W_ONE, -W_ONE);
    endtask

    // saturating products, exits on an empty stack and at level zero
    task automatic test_push_extremes();
        send_cmd(OP_EXIT);                  // empty stack, level zero
        send_cmd(OP_ENTER);
        send_cmd(OP_EXIT);                  // empty stack, level one
        send_cmd(OP_ENTER);
        send_push(W_MAX, W_MAX, W_MAX, W_MAX, W_MAX, W_MAX);
        send_map(W_ONE, W_ONE);
        send_push(W_MIN, W_MIN, W_MIN, W_MIN, W_MIN, W_MIN);
        send_map(W_MAX, W_MIN);
        send_cmd(OP_EXIT);                  // pops the second push
        send_map(W_ONE, '0);
        send_cmd(OP_EXIT);                  // top was pushed one level up: no pop
        send_cmd(OP_ENTER);
        send_cmd(OP_EXIT);                  // now it pops
        send_push(rand_unit(), '0, '0, rand_unit(), W_MAX, W_MIN);
        send_map(W_MIN, W_MAX);
        send_cmd(OP_EXIT);                  // pushed at level zero: pop, status exit-zero
        unwind_stack();
    endtask

    // fill the stack, drop one push, then pop every entry at level zero
    task automatic test_stack_full();
        for (int i = 0; i < STACK; i++)
            send_push(rand_unit(), rand_unit() >>> 3, rand_unit() >>> 3, rand_unit(),
                      rand_offset(), rand_offset());
        send_rand_push();
        send_map(rand_offset(), rand_offset());
        for (int i = 0; i < STACK; i++)
            send_cmd(OP_EXIT);
        send_map(rand_offset(), rand_offset());
        unwind_stack();
    endtask

    // climb past the nesting limit, push there, then all the way back
    task automatic test_nesting_limit();
        for (int i = 0; i <= NEST; i++)
            send_cmd(OP_ENTER);
        send_push(rand_unit(), '0, '0, rand_unit(), rand_offset(), rand_offset());
        send_map(rand_offset(), rand_offset());
        for (int i = 0; i <= NEST; i++)
            send_cmd(OP_EXIT);
        send_map(rand_offset(), rand_offset());
        unwind_stack();
    endtask

    // Mostly well-formed enter/push/map/exit groups, some nested one
    // deeper, with stray commands of random content between them.
    task automatic test_random(input int n_items);
        int first;
        int n_maps;
        first = items_sent;
        while (items_sent - first < n_items)
        begin
            if ($urandom_range(0, 99) < 78)
            begin
                send_cmd(OP_ENTER);
                send_rand_push();
                if ($urandom_range(0, 9) == 0)
                    send_rand_push();
                n_maps = $urandom_range(1, 4);
                for (int i = 0; i < n_maps; i++)
                    send_map(rand_offset(), rand_offset());
                if ($urandom_range(0, 3) == 0)
                begin
                    send_cmd(OP_ENTER);
                    send_rand_push();
                    send_map(rand_offset(), rand_offset());
                    send_cmd(OP_EXIT);
                    send_map(rand_offset(), rand_offset());
                end
                send_cmd(OP_EXIT);
            end
            else
                send_request('{op: op_t'($urandom_range(0, 3)),
                               a: $urandom, b: $urandom, c: $urandom, d: $urandom,
                               e: $urandom, f: $urandom, px: $urandom, py: $urandom});
        end
        unwind_stack();
    endtask

    // ------------------------------------------------------------------
    // Result side
    // ------------------------------------------------------------------

    // output stall: drawn at random with about 12 percent chance, none while quiet
    always @(negedge clk)
    begin
        out_stall = rst_n && !quiet && ($urandom_range(0, 99) < 12);
    end

    // every accepted result is matched against the oldest prediction
    always @(posedge clk)
    begin : check_results
        xf_result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_results.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("%0t: result with no request waiting: x=%h y=%h status=%0d",
                             $realtime, mapped_x, mapped_y, status);
            end
            else
            begin
                want = pending_results.pop_front();
                if (mapped_x !== want.x || mapped_y !== want.y || status !== want.st)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("%0t: expected x=%h y=%h status=%0d, got x=%h y=%h status=%0d",
                                 $realtime, want.x, want.y, want.st,
                                 mapped_x, mapped_y, status);
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Sequence of the run
    // ------------------------------------------------------------------
    initial
    begin : run
        int guard;
        reset_transform_state();
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        set_viewport('0);
        test_map_extremes();
        set_viewport({VH_W{1'b1}});
        test_map_extremes();
        set_viewport(VH_W'($urandom));
        test_push_extremes();
        test_stack_full();
        test_nesting_limit();

        // random part in four phases; the second runs with no idling
        for (int phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0:       set_viewport('0);
                1:       set_viewport({VH_W{1'b1}});
                default: set_viewport(VH_W'($urandom));
            endcase
            quiet = (phase == 1);
            test_random(200);
        end
        quiet = 1'b0;

        idle_inputs();
        guard = 0;
        while (pending_results.size() != 0 && guard < 5000)
        begin
            @(posedge clk);
            guard++;
        end
        repeat (40) @(posedge clk);

        if (mismatch_count == 0 && pending_results.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

// ===== sim.f =====
hdl/ats_pkg.sv
hdl/ats_ram.sv
hdl/ats_fifo.sv
hdl/ats_front.sv
hdl/ats_comb.sv
hdl/ats_back.sv
hdl/affine_transform_stack_unit.sv
verif/affine_transform_stack_unit_test.sv
